// File: rtl/tga_rle_pkg.sv
// Shared types and constants for the TGA run-length decoder.
`default_nettype none

package tga_rle_pkg;

  // How a pixel job ends: plain, last pixel of the image, or image overrun.
  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_DONE = 2'd1,
    END_OVF  = 2'd2
  } end_kind_e;

  // One completed pixel and how many copies of it go out.
  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  count;
    end_kind_e   kind;
  } pixel_job_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;

  // Packet header coding.
  localparam logic [7:0] RUN_FLAG = 8'd128;
  localparam logic [7:0] RUN_BIAS = 8'd127;

endpackage

`default_nettype wire

// File: rtl/tga_rle_front.sv
// Front end: packet header parsing, pixel assembly and image bookkeeping.
`default_nettype none

module tga_rle_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [7:0]              stream_byte_i,
  input  wire logic [31:0]             total_i,
  input  wire logic [2:0]              pix_size_i,
  output logic                         job_valid_o,
  output tga_rle_pkg::pixel_job_t      job_o,
  input  wire logic                    job_ready_i
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RAW    = 3'b010,
    PH_RUN    = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  bip_q, bip_d;
  logic [23:0] gather_q, gather_d;
  logic [31:0] done_q, done_d;

  logic        fire;
  logic [2:0]  bip_inc;
  logic [2:0]  size_m1;
  logic [31:0] byte_sh;
  logic [31:0] value;
  logic [31:0] remaining;
  logic        exhausted;
  logic [31:0] count_ext;
  logic [7:0]  left_dec;

  assign in_ready_o = job_ready_i;
  assign fire       = in_valid_i & job_ready_i;

  assign bip_inc   = {1'b0, bip_q} + 3'd1;
  assign size_m1   = pix_size_i - 3'd1;
  assign byte_sh   = {24'd0, stream_byte_i} << {bip_q, 3'b000};
  assign value     = {8'd0, gather_q} | ({24'd0, stream_byte_i} << {size_m1[1:0], 3'b000});
  assign remaining = total_i - done_q;
  assign exhausted = (done_q >= total_i);
  assign count_ext = {24'd0, left_q};
  assign left_dec  = left_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    bip_d       = bip_q;
    gather_d    = gather_q;
    done_d      = done_q;
    job_valid_o = 1'b0;
    job_o.value = value;
    job_o.count = 8'd0;
    job_o.kind  = tga_rle_pkg::END_NONE;

    if (fire) begin
      if ((phase_q == PH_HEADER) || (left_q == 8'd0)) begin
        if (stream_byte_i < tga_rle_pkg::RUN_FLAG) begin
          phase_d = PH_RAW;
          left_d  = stream_byte_i + 8'd1;
        end else begin
          phase_d = PH_RUN;
          left_d  = stream_byte_i - tga_rle_pkg::RUN_BIAS;
        end
        bip_d    = 2'd0;
        gather_d = 24'd0;
      end else if (bip_inc < pix_size_i) begin
        gather_d = gather_q | byte_sh[23:0];
        bip_d    = bip_inc[1:0];
      end else begin
        // Pixel complete: hand it on with its copy count and ending.
        bip_d       = 2'd0;
        gather_d    = 24'd0;
        job_valid_o = 1'b1;
        if (exhausted) begin
          job_o.count = 8'd0;
          job_o.kind  = tga_rle_pkg::END_OVF;
        end else if (phase_q == PH_RAW) begin
          job_o.count = 8'd1;
          if ((remaining == 32'd1) && (left_dec == 8'd0)) begin
            job_o.kind = tga_rle_pkg::END_DONE;
          end
        end else if (count_ext < remaining) begin
          job_o.count = left_q;
        end else if (count_ext == remaining) begin
          job_o.count = left_q;
          job_o.kind  = tga_rle_pkg::END_DONE;
        end else begin
          // Run passes the image end: only the pixels that fit go out.
          job_o.count = remaining[7:0];
          job_o.kind  = tga_rle_pkg::END_OVF;
        end

        if (job_o.kind != tga_rle_pkg::END_NONE) begin
          phase_d = PH_HEADER;
          left_d  = 8'd0;
          done_d  = 32'd0;
        end else if (phase_q == PH_RAW) begin
          done_d = done_q + 32'd1;
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = PH_HEADER;
          end
        end else begin
          done_d  = done_q + count_ext;
          phase_d = PH_HEADER;
          left_d  = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      left_q   <= 8'd0;
      bip_q    <= 2'd0;
      gather_q <= 24'd0;
      done_q   <= 32'd0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      bip_q    <= bip_d;
      gather_q <= gather_d;
      done_q   <= done_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tga_rle_fifo.sv
// Short job queue between the front and back ends.
`default_nettype none

module tga_rle_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_valid_i,
  output logic                         wr_ready_o,
  input  wire tga_rle_pkg::pixel_job_t wr_data_i,
  output logic                         rd_valid_o,
  input  wire logic                    rd_ready_i,
  output tga_rle_pkg::pixel_job_t      rd_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tga_rle_pkg::pixel_job_t slot_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != CntW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;
  assign rd_data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tga_rle_back.sv
// Back end: expands pixel jobs into results of up to two pixels.
`default_nettype none

module tga_rle_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    job_valid_i,
  output logic                         job_ready_o,
  input  wire tga_rle_pkg::pixel_job_t job_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [31:0]                  first_pixel_o,
  output logic [31:0]                  second_pixel_o,
  output logic [1:0]                   pixel_valid_count_o,
  output logic                         last_of_input_o,
  output logic                         image_done_o,
  output logic                         overflow_error_o
);

  logic                      busy_q;
  tga_rle_pkg::pixel_job_t   job_q;
  logic [7:0]                left_q;

  logic        out_valid_q;
  logic [31:0] first_q, second_q;
  logic [1:0]  count_q;
  logic        last_q, done_q, err_q;

  logic        emit, fin, load;
  logic [1:0]  cnt;

  assign emit = busy_q & (~out_valid_q | out_ready_i);
  // An overrun ends on its pending pixel, possibly none; other jobs on their last pair.
  assign fin  = (job_q.kind == tga_rle_pkg::END_OVF) ? (left_q <= 8'd1) : (left_q <= 8'd2);
  assign cnt  = fin ? left_q[1:0] : 2'd2;
  assign load = job_valid_i & (~busy_q | (emit & fin));

  assign job_ready_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (emit) begin
      first_q  <= (cnt != 2'd0) ? job_q.value : 32'd0;
      second_q <= (cnt == 2'd2) ? job_q.value : 32'd0;
      count_q  <= cnt;
      last_q   <= fin;
      done_q   <= fin & (job_q.kind == tga_rle_pkg::END_DONE);
      err_q    <= fin & (job_q.kind == tga_rle_pkg::END_OVF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      left_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        left_q <= job_i.count;
      end else if (emit) begin
        busy_q <= ~fin;
        left_q <= left_q - 8'd2;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign first_pixel_o       = first_q;
  assign second_pixel_o      = second_q;
  assign pixel_valid_count_o = count_q;
  assign last_of_input_o     = last_q;
  assign image_done_o        = done_q;
  assign overflow_error_o    = err_q;

endmodule

`default_nettype wire

// File: rtl/tga_rle_decoder_core.sv
// Top level of the TGA run-length decoder: config registers, front, queue, back.
// A pixel-completing byte passes the job queue, back-end job register and result register.
// Throughput: one stream byte per cycle while the job queue has room, header and
//   partial-pixel bytes too. The back end gives one result per cycle unless the output
//   stalls; n run pixels give ceil(n/2) results, one more if an overrun ends on even n.
// Reset (rst_ni low, async): control clear, queue empty, width 1, height 1, 3 bytes/pixel.
`default_nettype none

module tga_rle_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input stream, one byte per beat
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  stream_byte_i,
  // result stream
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      first_pixel_o,
  output logic [31:0]      second_pixel_o,
  output logic [1:0]       pixel_valid_count_o,
  output logic             last_of_input_o,
  output logic             image_done_o,
  output logic             overflow_error_o
);

  // ---------------------------------------------------------------------------
  // Configuration. The pixel total is multiplied at write time so the front
  // end sees a ready product and the multiplier stays off the byte path.
  // ---------------------------------------------------------------------------
  logic [15:0] width_q, height_q;
  logic [2:0]  bpp_q;
  logic [31:0] total_q;
  logic [15:0] width_nx, height_nx;
  logic [2:0]  pix_size;

  assign width_nx  = (cfg_we_i && cfg_index_i == tga_rle_pkg::REG_WIDTH)  ? cfg_wdata_i : width_q;
  assign height_nx = (cfg_we_i && cfg_index_i == tga_rle_pkg::REG_HEIGHT) ? cfg_wdata_i : height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
      bpp_q    <= 3'd3;
      total_q  <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tga_rle_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i;
        tga_rle_pkg::REG_HEIGHT: height_q <= cfg_wdata_i;
        tga_rle_pkg::REG_BPP:    bpp_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
      total_q <= {16'd0, width_nx} * {16'd0, height_nx};
    end
  end

  // Pixel size clamp: zero acts as one byte, five and up as four.
  always_comb begin
    if (bpp_q == 3'd0) begin
      pix_size = 3'd1;
    end else if (bpp_q > 3'd4) begin
      pix_size = 3'd4;
    end else begin
      pix_size = bpp_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: parses packets, assembles pixels and resolves the image end,
  // so each job already knows how many copies go out and how it finishes.
  // ---------------------------------------------------------------------------
  logic                    fj_valid, fj_ready;
  tga_rle_pkg::pixel_job_t fj_job;
  logic                    bj_valid, bj_ready;
  tga_rle_pkg::pixel_job_t bj_job;

  tga_rle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stream_byte_i(stream_byte_i),
    .total_i      (total_q),
    .pix_size_i   (pix_size),
    .job_valid_o  (fj_valid),
    .job_o        (fj_job),
    .job_ready_i  (fj_ready)
  );

  // Job queue: lets the input keep flowing while a long run is expanded.
  tga_rle_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fj_valid),
    .wr_ready_o(fj_ready),
    .wr_data_i (fj_job),
    .rd_valid_o(bj_valid),
    .rd_ready_i(bj_ready),
    .rd_data_o (bj_job)
  );

  // Back end: one registered result per cycle unless stalled, pixel pairs, flags on last.
  tga_rle_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (bj_valid),
    .job_ready_o        (bj_ready),
    .job_i              (bj_job),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .first_pixel_o      (first_pixel_o),
    .second_pixel_o     (second_pixel_o),
    .pixel_valid_count_o(pixel_valid_count_o),
    .last_of_input_o    (last_of_input_o),
    .image_done_o       (image_done_o),
    .overflow_error_o   (overflow_error_o)
  );

endmodule

`default_nettype wire
